// ----- hw/rtl/vpps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vpps_pkg;

  // Default tick period in milliseconds
  localparam int unsigned MsPerTickDefault = 8;

  // Stream payload widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] PatternCount = 3'd6;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Built-in pattern entry, times in ms
  typedef struct packed {
    logic [TimeW-1:0]  on_ms;
    logic [TimeW-1:0]  off_ms;
    logic [CountW-1:0] count;
  } pattern_t;

  // Decoded item as held in the input register
  typedef struct packed {
    func_e             kind;
    logic              start_en;
    logic [TimeW-1:0]  on_ticks;
    logic [TimeW-1:0]  off_ticks;
    logic [CountW-1:0] count;
  } item_t;

  // Built-in pattern table; unused indexes read as an empty pattern
  function automatic pattern_t pattern_lookup(input logic [IdxW-1:0] idx);
    pattern_t p;
    case (idx)
      3'd0:    p = '{on_ms: 16'h0100, off_ms: 16'h0100, count: 8'd2};
      3'd1:    p = '{on_ms: 16'h0180, off_ms: 16'h0080, count: 8'd3};
      3'd2:    p = '{on_ms: 16'h00C8, off_ms: 16'h01F4, count: 8'd1};
      3'd3:    p = '{on_ms: 16'h0200, off_ms: 16'h0200, count: 8'd5};
      3'd4:    p = '{on_ms: 16'h0100, off_ms: 16'h0100, count: 8'd5};
      3'd5:    p = '{on_ms: 16'h03E8, off_ms: 16'h03E8, count: 8'd1};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vpps_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pattern selection and ms-to-tick conversion ahead of the input register
module vpps_decode import vpps_pkg::*; #(
  parameter int unsigned MS_PER_TICK = MsPerTickDefault
) (
  input  wire logic [1:0]        func_i,
  input  wire logic              use_table_i,
  input  wire logic [IdxW-1:0]   pattern_index_i,
  input  wire logic              enable_i,
  input  wire logic [TimeW-1:0]  on_ms_i,
  input  wire logic [TimeW-1:0]  off_ms_i,
  input  wire logic [CountW-1:0] cycles_i,
  output item_t                  item_o
);

  // Exact reciprocal for 16-bit dividends: m = ceil(2^(16+l) / d)
  localparam int unsigned Shift    = TimeW + $clog2(MS_PER_TICK);
  localparam int unsigned RecipInt = ((32'd1 << Shift) + MS_PER_TICK - 1) / MS_PER_TICK;
  localparam int unsigned RecipW   = TimeW + 1;
  localparam int unsigned ProdW    = Shift + TimeW;
  localparam logic [RecipW-1:0] Recip = RecipInt[RecipW-1:0];

  pattern_t          tbl;
  logic              tbl_ok;
  logic [TimeW-1:0]  on_ms_sel;
  logic [TimeW-1:0]  off_ms_sel;
  logic [ProdW-1:0]  on_prod;
  logic [ProdW-1:0]  off_prod;

  assign tbl    = pattern_lookup(pattern_index_i);
  assign tbl_ok = (pattern_index_i < PatternCount);

  // Source of the pattern: table or custom fields
  always_comb begin
    if (use_table_i) begin
      on_ms_sel  = tbl.on_ms;
      off_ms_sel = tbl.off_ms;
    end else begin
      on_ms_sel  = on_ms_i;
      off_ms_sel = off_ms_i;
    end
  end

  // Divide by the tick period through the reciprocal
  assign on_prod  = ProdW'(on_ms_sel) * ProdW'(Recip);
  assign off_prod = ProdW'(off_ms_sel) * ProdW'(Recip);

  always_comb begin
    item_o.kind      = func_e'(func_i);
    item_o.start_en  = use_table_i ? tbl_ok : enable_i;
    item_o.on_ticks  = on_prod[Shift +: TimeW];
    item_o.off_ticks = off_prod[Shift +: TimeW];
    item_o.count     = use_table_i ? tbl.count : cycles_i;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vibration_pulse_pattern_sequencer_top.sv -----
// An accepted item waits in the input register; when it advances, its result is loaded
// into the result register. One item per cycle while the result side is not stalled;
// the state update is one combinational pass per item.
// A stalled result holds in the output register; the input register takes one more item.
// Reset (rst_ni low, asynchronous): motor off, no event, all counters and times cleared,
// both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module vibration_pulse_pattern_sequencer_top import vpps_pkg::*; #(
  parameter int unsigned MS_PER_TICK = MsPerTickDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [0] use_table, [3:1] pattern_index, [4] enable, [20:5] on_ms,
  // [36:21] off_ms, [44:37] cycles, [47:45] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  wire logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [0] motor_on, [1] active, [7:2] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  item_t             dec_item;
  item_t             item_q;
  logic              item_vld_q;
  logic              advance;

  logic              active_q, active_d;
  logic              motor_q, motor_d;
  logic [CountW-1:0] cycles_left_q, cycles_left_d;
  logic [TimeW-1:0]  tick_cnt_q, tick_cnt_d;
  logic [TimeW-1:0]  on_ticks_q, on_ticks_d;
  logic [TimeW-1:0]  off_ticks_q, off_ticks_d;
  logic [TimeW-1:0]  next_act_q, next_act_d;
  logic [TimeW-1:0]  tick_inc;

  logic              out_vld_q;
  logic [1:0]        out_bits_q;

  vpps_decode #(
    .MS_PER_TICK(MS_PER_TICK)
  ) u_decode (
    .func_i         (s_axis_tuser_i),
    .use_table_i    (s_axis_tdata_i[0]),
    .pattern_index_i(s_axis_tdata_i[3:1]),
    .enable_i       (s_axis_tdata_i[4]),
    .on_ms_i        (s_axis_tdata_i[20:5]),
    .off_ms_i       (s_axis_tdata_i[36:21]),
    .cycles_i       (s_axis_tdata_i[44:37]),
    .item_o         (dec_item)
  );

  // Handshake: item moves on when the result register is free or drains
  assign advance         = item_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      item_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q <= dec_item;
    end
  end

  // Sequencer update for one item
  assign tick_inc = tick_cnt_q + TimeW'(1);

  always_comb begin
    active_d      = active_q;
    motor_d       = motor_q;
    cycles_left_d = cycles_left_q;
    tick_cnt_d    = tick_cnt_q;
    on_ticks_d    = on_ticks_q;
    off_ticks_d   = off_ticks_q;
    next_act_d    = next_act_q;
    case (item_q.kind)
      FUNC_TICK: begin
        tick_cnt_d = tick_inc;
        if (active_q && (tick_inc >= next_act_q)) begin
          if (motor_q) begin
            // on-to-off edge: count down, last cycle ends the event
            motor_d    = 1'b0;
            next_act_d = next_act_q + off_ticks_q;
            if (cycles_left_q > CountW'(1)) begin
              cycles_left_d = cycles_left_q - CountW'(1);
            end else begin
              active_d = 1'b0;
            end
          end else begin
            motor_d    = 1'b1;
            next_act_d = next_act_q + on_ticks_q;
          end
        end
      end
      FUNC_START: begin
        active_d = item_q.start_en;
        motor_d  = item_q.start_en;
        if (item_q.start_en) begin
          on_ticks_d    = item_q.on_ticks;
          off_ticks_d   = item_q.off_ticks;
          cycles_left_d = item_q.count;
          tick_cnt_d    = '0;
          next_act_d    = item_q.on_ticks;
        end else begin
          next_act_d = on_ticks_q;
        end
      end
      FUNC_STOP: begin
        active_d   = 1'b0;
        motor_d    = 1'b0;
        next_act_d = on_ticks_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      motor_q       <= 1'b0;
      cycles_left_q <= '0;
      tick_cnt_q    <= '0;
      on_ticks_q    <= '0;
      off_ticks_q   <= '0;
      next_act_q    <= '0;
    end else if (advance) begin
      active_q      <= active_d;
      motor_q       <= motor_d;
      cycles_left_q <= cycles_left_d;
      tick_cnt_q    <= tick_cnt_d;
      on_ticks_q    <= on_ticks_d;
      off_ticks_q   <= off_ticks_d;
      next_act_q    <= next_act_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_bits_q <= {active_d, motor_d};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OutDataW - 2)'(0), out_bits_q};

  // The motor never runs outside an event
  assert property (@(posedge clk_i) disable iff (!rst_ni) motor_q |-> active_q)
    else $error("motor on without an active event");

  // A held item does not change while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && !advance) |=> (item_vld_q && $stable(item_q)))
    else $error("held item changed during stall");

  // A tick with no event never starts one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_q.kind == FUNC_TICK) && !active_q) |=> !active_q)
    else $error("tick started an event");

  // An enabled start clears the tick counter and drives the motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_q.kind == FUNC_START) && item_q.start_en)
      |=> (tick_cnt_q == '0) && motor_q && active_q)
    else $error("start did not load the pattern");

endmodule

`default_nettype wire
